### design/lcdms_pkg.sv
// ----------------------------------------------------------------------------
// lcdms_pkg: shared types and codes for the LCD line/mode sequencer
// Mode codes, config index codes, state, configuration and interrupt records.
// ----------------------------------------------------------------------------
package lcdms_pkg;

    localparam logic [1:0] MODE_HBL  = 2'd0;
    localparam logic [1:0] MODE_VBL  = 2'd1;
    localparam logic [1:0] MODE_SCAN = 2'd2;
    localparam logic [1:0] MODE_DRAW = 2'd3;

    localparam logic [1:0] CFG_LINE_COMPARE   = 2'd0;
    localparam logic [1:0] CFG_MATCH_IRQ_EN   = 2'd1;
    localparam logic [1:0] CFG_VBLANK_IRQ_EN  = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  line;
        logic [8:0]  dot;
        logic        match;
        logic [31:0] frames;
    } t_state;

    typedef struct packed {
        logic [7:0] line_compare;
        logic       match_irq_en;
        logic       vblank_irq_en;
    } t_cfg;

    typedef struct packed {
        logic vblank_irq;
        logic status_irq;
    } t_irq;

endpackage

### design/lcdms_step.sv
// ----------------------------------------------------------------------------
// lcdms_step: next-state logic for one dot tick
// Dot count, mode steps, line end, vblank entry, wrap and line compare.
// ----------------------------------------------------------------------------
module lcdms_step #(
    parameter int DOTS_PER_LINE = 456,
    parameter int VISIBLE_LINES = 144,
    parameter int TOTAL_LINES   = 154,
    parameter int SCAN_DOTS     = 80,
    parameter int TRANSFER_DOTS = 172
) (
    input  lcdms_pkg::t_state i_state,
    input  lcdms_pkg::t_cfg   i_cfg,
    input  logic              i_advance,
    output lcdms_pkg::t_state o_state,
    output lcdms_pkg::t_irq   o_irq
);

    localparam int XFER_END = SCAN_DOTS + TRANSFER_DOTS;

    logic [8:0] dot_inc;
    logic [7:0] line_inc;
    logic       line_end;

    assign dot_inc  = i_state.dot + 9'd1;
    assign line_inc = i_state.line + 8'd1;
    assign line_end = ({1'b0, dot_inc} >= 10'(DOTS_PER_LINE));

    always_comb begin
        o_state = i_state;
        o_irq   = '0;
        if (i_advance) begin
            o_state.dot = dot_inc;
            if (line_end) begin
                o_state.dot  = '0;
                o_state.line = line_inc;
                if (i_state.mode == lcdms_pkg::MODE_VBL) begin
                    if ({1'b0, line_inc} >= 9'(TOTAL_LINES)) begin
                        o_state.line = '0;
                        o_state.mode = lcdms_pkg::MODE_SCAN;
                    end
                end else if ({1'b0, line_inc} >= 9'(VISIBLE_LINES)) begin
                    o_irq.vblank_irq = 1'b1;
                    o_irq.status_irq = i_cfg.vblank_irq_en;
                    o_state.frames   = i_state.frames + 32'd1;
                    o_state.mode     = lcdms_pkg::MODE_VBL;
                end else begin
                    o_state.mode = lcdms_pkg::MODE_SCAN;
                end
                // compare uses the line after the wrap, so line 0 is seen too
                o_state.match = (o_state.line == i_cfg.line_compare);
                if (o_state.match && i_cfg.match_irq_en) begin
                    o_irq.status_irq = 1'b1;
                end
            end else if (i_state.mode == lcdms_pkg::MODE_SCAN) begin
                if ({1'b0, dot_inc} >= 10'(SCAN_DOTS)) begin
                    o_state.mode = lcdms_pkg::MODE_DRAW;
                end
            end else if (i_state.mode == lcdms_pkg::MODE_DRAW) begin
                if ({1'b0, dot_inc} >= 10'(XFER_END)) begin
                    o_state.mode = lcdms_pkg::MODE_HBL;
                end
            end
        end
    end

endmodule

### design/lcd_line_mode_sequencer_unit.sv
// ----------------------------------------------------------------------------
// lcd_line_mode_sequencer_unit: LCD dot/line/mode timing sequencer
// One dot tick per input transaction with i_advance set (none when it is low); one status result per transaction.
// ----------------------------------------------------------------------------
// Result valid in the output register the cycle after input acceptance.
// Throughput: 1 transaction per cycle unless a held result stalls input; state
//   updates at acceptance via one combinational step, state to result register.
// Reset (synchronous, active low): dot 0, line 0, object scan mode, match 0,
//   frame count 0, all configuration registers 0, no result pending.
module lcd_line_mode_sequencer_unit #(
    parameter int DOTS_PER_LINE = 456,
    parameter int VISIBLE_LINES = 144,
    parameter int TOTAL_LINES   = 154,
    parameter int SCAN_DOTS     = 80,
    parameter int TRANSFER_DOTS = 172
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_advance,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_mode,
    output logic [7:0]  o_line,
    output logic [8:0]  o_dot,
    output logic        o_line_match,
    output logic        o_vblank_irq,
    output logic        o_status_irq,
    output logic [31:0] o_frames
);

    lcdms_pkg::t_cfg   r_cfg;
    lcdms_pkg::t_state r_state;
    lcdms_pkg::t_state n_state;
    lcdms_pkg::t_irq   n_irq;
    lcdms_pkg::t_state r_res;
    lcdms_pkg::t_irq   r_res_irq;
    logic              r_out_valid;
    logic              in_accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lcdms_pkg::CFG_LINE_COMPARE:  r_cfg.line_compare  <= i_cfg_data;
                lcdms_pkg::CFG_MATCH_IRQ_EN:  r_cfg.match_irq_en  <= i_cfg_data[0];
                lcdms_pkg::CFG_VBLANK_IRQ_EN: r_cfg.vblank_irq_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    lcdms_step #(
        .DOTS_PER_LINE (DOTS_PER_LINE),
        .VISIBLE_LINES (VISIBLE_LINES),
        .TOTAL_LINES   (TOTAL_LINES),
        .SCAN_DOTS     (SCAN_DOTS),
        .TRANSFER_DOTS (TRANSFER_DOTS)
    ) u_step (
        .i_state   (r_state),
        .i_cfg     (r_cfg),
        .i_advance (i_advance),
        .o_state   (n_state),
        .o_irq     (n_irq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{mode: lcdms_pkg::MODE_SCAN, line: '0, dot: '0,
                             match: 1'b0, frames: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with the post-update state
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res     <= n_state;
            r_res_irq <= n_irq;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mode       = r_res.mode;
    assign o_line       = r_res.line;
    assign o_dot        = r_res.dot;
    assign o_line_match = r_res.match;
    assign o_vblank_irq = r_res_irq.vblank_irq;
    assign o_status_irq = r_res_irq.status_irq;
    assign o_frames     = r_res.frames;

    a_vblank_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_vblank_irq) |-> (o_mode == lcdms_pkg::MODE_VBL))
        else $error("vblank pulse outside vblank mode");

    a_vblank_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_vblank_irq) |-> (o_line == 8'(VISIBLE_LINES) && o_dot == 9'd0))
        else $error("vblank pulse not at first vblank line start");

    a_status_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status_irq && !o_vblank_irq) |-> o_line_match)
        else $error("status pulse without a source");

    a_dot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_dot} < 10'(DOTS_PER_LINE)))
        else $error("dot beyond line length");

    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !n_irq.vblank_irq) |=> $stable(r_state.frames))
        else $error("frame count moved without vblank entry");

endmodule

### test/lcd_line_mode_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// lcd_line_mode_sequencer_unit_tb: dot/line/mode timing check
// Ticks dots through the first line and well into the second under changing
// compare and interrupt settings. Every transaction is predicted and each
// result is compared in order.
// ----------------------------------------------------------------------------
module lcd_line_mode_sequencer_unit_tb;

    localparam int DOTS_PER_LINE = 456;
    localparam int VISIBLE_LINES = 144;
    localparam int TOTAL_LINES   = 154;
    localparam int SCAN_DOTS     = 80;
    localparam int TRANSFER_DOTS = 172;
    localparam int STALL_LIMIT   = 2000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  line;
        logic [8:0]  dot;
        logic        line_match;
        logic        vblank_irq;
        logic        status_irq;
        logic [31:0] frames;
    } t_dot_status;

    class lcd_timing_scoreboard;
        logic [8:0]  dot_pos;
        logic [7:0]  line_no;
        logic [1:0]  mode_now;
        logic        match_now;
        logic [31:0] frame_cnt;
        logic [7:0]  cmp_line;
        logic        match_irq_on;
        logic        vblank_irq_on;
        t_dot_status status_q[$];
        int          errors;
        int          results_seen;

        function new();
            dot_pos       = '0;
            line_no       = '0;
            mode_now      = lcdms_pkg::MODE_SCAN;
            match_now     = 1'b0;
            frame_cnt     = '0;
            cmp_line      = '0;
            match_irq_on  = 1'b0;
            vblank_irq_on = 1'b0;
            errors        = 0;
            results_seen  = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        function void set_reg(logic [1:0] idx, logic [7:0] data);
            case (idx)
                lcdms_pkg::CFG_LINE_COMPARE:  cmp_line      = data;
                lcdms_pkg::CFG_MATCH_IRQ_EN:  match_irq_on  = data[0];
                lcdms_pkg::CFG_VBLANK_IRQ_EN: vblank_irq_on = data[0];
                default: ;
            endcase
        endfunction

        // one transaction accepted: advance the timing state if adv is set, queue the status
        function void note_tick(logic adv);
            t_dot_status want;
            logic [8:0]  d;
            logic        vb;
            logic        st;
            vb = 1'b0;
            st = 1'b0;
            if (adv) begin
                d = dot_pos + 9'd1;
                if (d >= DOTS_PER_LINE) begin
                    d = '0;
                    line_no = line_no + 8'd1;
                    if (mode_now == lcdms_pkg::MODE_VBL) begin
                        if (line_no >= TOTAL_LINES) begin
                            line_no  = '0;
                            mode_now = lcdms_pkg::MODE_SCAN;
                        end
                    end else if (line_no >= VISIBLE_LINES) begin
                        vb        = 1'b1;
                        st        = vblank_irq_on;
                        frame_cnt = frame_cnt + 32'd1;
                        mode_now  = lcdms_pkg::MODE_VBL;
                    end else begin
                        mode_now = lcdms_pkg::MODE_SCAN;
                    end
                    // line 0 is compared too
                    match_now = (line_no == cmp_line);
                    if (match_now && match_irq_on)
                        st = 1'b1;
                end else if (mode_now == lcdms_pkg::MODE_SCAN) begin
                    if (d >= SCAN_DOTS)
                        mode_now = lcdms_pkg::MODE_DRAW;
                end else if (mode_now == lcdms_pkg::MODE_DRAW) begin
                    if (d >= SCAN_DOTS + TRANSFER_DOTS)
                        mode_now = lcdms_pkg::MODE_HBL;
                end
                dot_pos = d;
            end
            want.mode       = mode_now;
            want.line       = line_no;
            want.dot        = dot_pos;
            want.line_match = match_now;
            want.vblank_irq = vb;
            want.status_irq = st;
            want.frames     = frame_cnt;
            status_q.push_back(want);
        endfunction

        task check_status(t_dot_status got);
            t_dot_status want;
            int          n;
            n = results_seen;
            results_seen++;
            if (status_q.size() == 0) begin
                report($sformatf("result %0d arrived with no tick pending", n));
                return;
            end
            want = status_q.pop_front();
            if (got.mode !== want.mode)
                report($sformatf("result %0d mode %0d, want %0d", n, got.mode, want.mode));
            if (got.line !== want.line)
                report($sformatf("result %0d line %0d, want %0d", n, got.line, want.line));
            if (got.dot !== want.dot)
                report($sformatf("result %0d dot %0d, want %0d", n, got.dot, want.dot));
            if (got.line_match !== want.line_match)
                report($sformatf("result %0d line_match %0b, want %0b", n,
                                 got.line_match, want.line_match));
            if (got.vblank_irq !== want.vblank_irq)
                report($sformatf("result %0d vblank_irq %0b, want %0b", n,
                                 got.vblank_irq, want.vblank_irq));
            if (got.status_irq !== want.status_irq)
                report($sformatf("result %0d status_irq %0b, want %0b", n,
                                 got.status_irq, want.status_irq));
            if (got.frames !== want.frames)
                report($sformatf("result %0d frames %0d, want %0d", n,
                                 got.frames, want.frames));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_advance;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_mode;
    logic [7:0]  o_line;
    logic [8:0]  o_dot;
    logic        o_line_match;
    logic        o_vblank_irq;
    logic        o_status_irq;
    logic [31:0] o_frames;

    lcd_timing_scoreboard sb;
    bit                   steady;
    int                   stall_cycles;

    lcd_line_mode_sequencer_unit #(
        .DOTS_PER_LINE (DOTS_PER_LINE),
        .VISIBLE_LINES (VISIBLE_LINES),
        .TOTAL_LINES   (TOTAL_LINES),
        .SCAN_DOTS     (SCAN_DOTS),
        .TRANSFER_DOTS (TRANSFER_DOTS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_advance    (i_advance),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_mode       (o_mode),
        .o_line       (o_line),
        .o_dot        (o_dot),
        .o_line_match (o_line_match),
        .o_vblank_irq (o_vblank_irq),
        .o_status_irq (o_status_irq),
        .o_frames     (o_frames)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // all tasks start and end on a falling edge
    task automatic write_config(input logic [7:0] cmp, input logic men, input logic ven);
        logic [7:0] men_word;
        logic [7:0] ven_word;
        // junk above bit 0 must be dropped by the block
        men_word = {7'($urandom), men};
        ven_word = {7'($urandom), ven};
        i_cfg_we    <= 1'b1;
        i_cfg_index <= lcdms_pkg::CFG_LINE_COMPARE;
        i_cfg_data  <= cmp;
        sb.set_reg(lcdms_pkg::CFG_LINE_COMPARE, cmp);
        @(negedge i_clk);
        i_cfg_index <= lcdms_pkg::CFG_MATCH_IRQ_EN;
        i_cfg_data  <= men_word;
        sb.set_reg(lcdms_pkg::CFG_MATCH_IRQ_EN, men_word);
        @(negedge i_clk);
        i_cfg_index <= lcdms_pkg::CFG_VBLANK_IRQ_EN;
        i_cfg_data  <= ven_word;
        sb.set_reg(lcdms_pkg::CFG_VBLANK_IRQ_EN, ven_word);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic push_tick(input logic adv);
        while (!steady && $urandom_range(99) < 20) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_advance  <= adv;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_tick(adv);
        @(negedge i_clk);
    endtask

    // mostly advancing ticks, with the odd hold mixed in
    task automatic run_to_line(input logic [7:0] target);
        while (sb.line_no != target)
            push_tick($urandom_range(7) != 0);
    endtask

    task automatic drain_status();
        i_in_valid <= 1'b0;
        while (sb.status_q.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= steady || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        t_dot_status got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.mode       = o_mode;
            got.line       = o_line;
            got.dot        = o_dot;
            got.line_match = o_line_match;
            got.vblank_irq = o_vblank_irq;
            got.status_irq = o_status_irq;
            got.frames     = o_frames;
            sb.check_status(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("lcd_line_mode_sequencer_unit verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        sb           = new();
        steady       = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = lcdms_pkg::CFG_LINE_COMPARE;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_advance    = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: holds out of reset (line 0 equals compare but no match yet), then dot ticks mixed with holds
        write_config(8'd0, 1'b0, 1'b0);
        repeat (3) push_tick(1'b0);
        repeat (6) push_tick(1'b1);
        repeat (2) push_tick(1'b0);
        repeat (8) push_tick(1'b1);
        push_tick(1'b0);
        push_tick(1'b1);
        drain_status();

        // scan, transfer and hblank of line 0, then a match with interrupt on line 1
        write_config(8'd1, 1'b1, 1'b1);
        run_to_line(8'd1);
        drain_status();

        // long stretch with no idling on either side
        steady = 1'b1;
        write_config(8'($urandom_range(153)), 1'($urandom), 1'($urandom));
        repeat (230) push_tick($urandom_range(7) != 0);
        drain_status();
        steady = 1'b0;

        if (sb.status_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.status_q.size()));
        if (sb.errors == 0)
            $display("lcd_line_mode_sequencer_unit verification clean");
        else
            $display("lcd_line_mode_sequencer_unit verification failed");
        $finish;
    end
endmodule
